[hw/rtl/rpt_pkg.sv]
// ----------------------------------------------------------------------------
// rpt_pkg
// shared widths, register map and the state/result structs of the period
// tracker
// ----------------------------------------------------------------------------
package rpt_pkg;

   localparam int TIME_W     = 32;
   localparam int ACC_W      = 48;
   localparam int COUNT_W    = 16;
   localparam int SLOT_OUT_W = 4;
   localparam int SHIFT_W    = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd4;

   // register index, taken from csr address bit 2
   localparam logic REG_WINDOW_SHIFT = 1'b0;

   typedef struct packed {
      logic [TIME_W-1:0]  last_edge_time;
      logic [TIME_W-1:0]  last_gap;
      logic [TIME_W-1:0]  turn_start;
      logic [ACC_W-1:0]   acc;
      logic [COUNT_W-1:0] turns;
   } track_state_type;

   typedef struct packed {
      logic               new_turn;
      logic [TIME_W-1:0]  turn_period;
      logic [TIME_W-1:0]  turn_start;
      logic [TIME_W-1:0]  mean_period;
      logic [COUNT_W-1:0] turn_count;
   } track_result_type;

endpackage

[hw/rtl/rpt_update.sv]
// ----------------------------------------------------------------------------
// rpt_update
// one edge beat: new-turn test, period, moving average and turn count
// ----------------------------------------------------------------------------
module rpt_update
   import rpt_pkg::*;
(
   input  track_state_type         state_cur,
   input  logic [TIME_W-1:0]       edge_time,
   input  logic [SHIFT_W-1:0]      window_shift,
   output logic                    turn,
   output track_state_type         state_nxt,
   output track_result_type        result
);

   logic [TIME_W-1:0] gap;
   logic [TIME_W:0]   limit;
   logic [TIME_W-1:0] period;
   logic [ACC_W-1:0]  acc_upd;
   logic [ACC_W-1:0]  acc_new;
   logic [ACC_W-1:0]  mean_wide;

   assign gap     = edge_time - state_cur.last_edge_time;
   assign limit   = {1'b0, state_cur.last_gap} + {2'b00, state_cur.last_gap[TIME_W-1:1]};
   assign turn    = {1'b0, gap} > limit;
   assign period  = edge_time - state_cur.turn_start;
   assign acc_upd = state_cur.acc - (state_cur.acc >> window_shift)
                    + {{(ACC_W-TIME_W){1'b0}}, period};
   assign acc_new = turn ? acc_upd : state_cur.acc;
   assign mean_wide = acc_new >> window_shift;

   always_comb begin
      state_nxt.last_edge_time = edge_time;
      state_nxt.last_gap       = gap;
      state_nxt.turn_start     = turn ? edge_time : state_cur.turn_start;
      state_nxt.acc            = acc_new;
      state_nxt.turns          = turn ? state_cur.turns + 1'b1 : state_cur.turns;

      result.new_turn    = turn;
      result.turn_period = turn ? period : '0;
      result.turn_start  = turn ? state_cur.turn_start : '0;
      result.mean_period = (|mean_wide[ACC_W-1:TIME_W]) ? '1 : mean_wide[TIME_W-1:0];
      result.turn_count  = state_nxt.turns;
   end

endmodule

[hw/rtl/revolution_period_tracker.sv]
// ----------------------------------------------------------------------------
// revolution_period_tracker
// turn detection and period averaging from beacon sensor edges
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   edge_time
//   rsp      out        rsp_valid / rsp_ready   new_turn, turn_period,
//                                                turn_start, slot_index,
//                                                mean_period, turn_count
//   csr      in         apb, pready tied high   window_shift at 0x0
//
// one beat per cycle while the output is not stalled: each edge is worked out
// in the accept cycle and registered in the output register at its end; the
// output register frees in the cycle it is taken, so req_ready stays high
// while rsp_ready is high
// synchronous reset clears all tracking state, window_shift returns to 4
// ----------------------------------------------------------------------------
module revolution_period_tracker
   import rpt_pkg::*;
#(
   parameter int RING_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TIME_W-1:0]     req_edge_time,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_new_turn,
   output logic [TIME_W-1:0]     rsp_turn_period,
   output logic [TIME_W-1:0]     rsp_turn_start,
   output logic [SLOT_OUT_W-1:0] rsp_slot_index,
   output logic [TIME_W-1:0]     rsp_mean_period,
   output logic [COUNT_W-1:0]    rsp_turn_count,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int SLOT_W = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
   localparam int EXT_W  = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

   logic [SHIFT_W-1:0] window_shift_ff, window_shift_in;
   track_state_type    state_ff, state_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   logic               rsp_valid_ff, rsp_valid_in;
   track_result_type   result_ff, result_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;

   logic               accept;
   logic               turn;
   track_state_type    state_upd;
   logic               csr_write;
   logic [EXT_W-1:0]   slot_ext;

   rpt_update u_update (
      .state_cur    (state_ff),
      .edge_time    (req_edge_time),
      .window_shift (window_shift_ff),
      .turn         (turn),
      .state_nxt    (state_upd),
      .result       (result_in)
   );

   assign req_ready = ~reset & (~rsp_valid_ff | rsp_ready);
   assign accept    = req_valid & req_ready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      window_shift_in = window_shift_ff;
      if (csr_write && csr_paddr[2] == REG_WINDOW_SHIFT) begin
         window_shift_in = csr_pwdata[SHIFT_W-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == REG_WINDOW_SHIFT) begin
         csr_prdata = {{(CSR_DATA_W-SHIFT_W){1'b0}}, window_shift_ff};
      end
   end

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (accept) begin
         state_in     = state_upd;
         rsp_slot_in  = slot_ff;
         rsp_valid_in = 1'b1;
         if (turn) begin
            slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_shift_ff <= SHIFT_RESET;
         state_ff        <= '0;
         slot_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         window_shift_ff <= window_shift_in;
         state_ff        <= state_in;
         slot_ff         <= slot_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
      rsp_slot_ff <= rsp_slot_in;
   end

   assign slot_ext = EXT_W'(rsp_slot_ff);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_turn    = result_ff.new_turn;
   assign rsp_turn_period = result_ff.turn_period;
   assign rsp_turn_start  = result_ff.turn_start;
   assign rsp_slot_index  = slot_ext[SLOT_OUT_W-1:0];
   assign rsp_mean_period = result_ff.mean_period;
   assign rsp_turn_count  = result_ff.turn_count;

   a_accept_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted edge beat left no result");

   a_count_follows_state: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_turn_count == state_ff.turns)
      else $error("reported turn count differs from tracked count");

   a_no_turn_holds_count: assert property (@(posedge clock) disable iff (reset)
      accept && !turn |=> state_ff.turns == $past(state_ff.turns) &&
                          slot_ff == $past(slot_ff))
      else $error("count or slot moved without a new turn");

   a_turn_sets_start: assert property (@(posedge clock) disable iff (reset)
      accept && turn |=> state_ff.turn_start == $past(req_edge_time))
      else $error("turn start not taken from the edge");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !result_ff.new_turn |->
         result_ff.turn_period == '0 && result_ff.turn_start == '0)
      else $error("period or start nonzero on a plain edge");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// revolution_period_tracker testbench
// drives sensor edge timestamps through the req channel and checks every rsp
// beat against an in-bench turn tracker: 33-bit turn threshold, period and
// start date, moving-average mean with saturation, slot ring and turn count
// window_shift is written and read back over the csr port between phases,
// and both channels idle at random, with one long output stall
// ----------------------------------------------------------------------------
module testbench
   import rpt_pkg::*;
();

   localparam int RING_DEPTH  = 16;
   localparam int CYCLE_LIMIT = 400_000;
   localparam logic [CSR_ADDR_W-1:0] SHIFT_ADDR = {REG_WINDOW_SHIFT, 2'b00};

   typedef struct packed {
      logic                  new_turn;
      logic [TIME_W-1:0]     turn_period;
      logic [TIME_W-1:0]     turn_start;
      logic [SLOT_OUT_W-1:0] slot_index;
      logic [TIME_W-1:0]     mean_period;
      logic [COUNT_W-1:0]    turn_count;
   } turn_result_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [TIME_W-1:0]     req_edge_time = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic                  rsp_new_turn;
   logic [TIME_W-1:0]     rsp_turn_period;
   logic [TIME_W-1:0]     rsp_turn_start;
   logic [SLOT_OUT_W-1:0] rsp_slot_index;
   logic [TIME_W-1:0]     rsp_mean_period;
   logic [COUNT_W-1:0]    rsp_turn_count;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // tracker state
   logic [TIME_W-1:0]     seen_edge_time  = '0;
   logic [TIME_W-1:0]     seen_gap        = '0;
   logic [TIME_W-1:0]     open_turn_start = '0;
   logic [ACC_W-1:0]      period_acc      = '0;
   logic [COUNT_W-1:0]    turn_total      = '0;
   logic [SLOT_OUT_W-1:0] pending_slot    = '0;
   logic [SHIFT_W-1:0]    avg_shift       = SHIFT_RESET;

   turn_result_type       pending_results[$];
   turn_result_type       oldest_result;
   logic [TIME_W-1:0]     stim_time = '0;
   int                    mismatch_count   = 0;
   int                    cycle_count      = 0;
   int                    tx_idle_pct      = 0;
   int                    rx_idle_pct      = 0;
   int                    long_hold_cycles = 0;
   int                    hold_done        = 0;

   revolution_period_tracker #(
      .RING_DEPTH(RING_DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_edge_time  (req_edge_time),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_new_turn   (rsp_new_turn),
      .rsp_turn_period(rsp_turn_period),
      .rsp_turn_start (rsp_turn_start),
      .rsp_slot_index (rsp_slot_index),
      .rsp_mean_period(rsp_mean_period),
      .rsp_turn_count (rsp_turn_count),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic turn_result_type track_edge(input logic [TIME_W-1:0] stamp);
      logic [TIME_W-1:0] gap;
      logic [TIME_W:0]   turn_limit;
      logic [ACC_W-1:0]  scaled;
      turn_result_type   r;
      gap        = stamp - seen_edge_time;
      turn_limit = {1'b0, seen_gap} + {2'b00, seen_gap[TIME_W-1:1]};
      r            = '0;
      r.slot_index = pending_slot;
      if ({1'b0, gap} > turn_limit) begin
         r.new_turn    = 1'b1;
         r.turn_period = stamp - open_turn_start;
         r.turn_start  = open_turn_start;
         period_acc    = period_acc - (period_acc >> avg_shift)
                         + {{(ACC_W-TIME_W){1'b0}}, r.turn_period};
         turn_total    = turn_total + 1'b1;
         pending_slot  = SLOT_OUT_W'((pending_slot + 1) % RING_DEPTH);
         open_turn_start = stamp;
      end
      seen_gap       = gap;
      seen_edge_time = stamp;
      scaled = period_acc >> avg_shift;
      r.mean_period = (scaled > {{(ACC_W-TIME_W){1'b0}}, {TIME_W{1'b1}}}) ?
                      {TIME_W{1'b1}} : scaled[TIME_W-1:0];
      r.turn_count  = turn_total;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // one edge beat, with a random sender gap after it
   task automatic send_edge(input logic [TIME_W-1:0] stamp);
      stim_time = stamp;
      req_valid     <= 1'b1;
      req_edge_time <= stamp;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(track_edge(stamp));
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic access_window_shift(input logic is_write,
                                      input logic [CSR_DATA_W-1:0] wdata);
      if (is_write)
         drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= SHIFT_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (is_write) begin
         avg_shift = wdata[SHIFT_W-1:0];
      end else if (csr_prdata[SHIFT_W-1:0] !== avg_shift) begin
         $display("%0t: window_shift readback mismatch, expected %h, actual %h",
                  $time, avg_shift, csr_prdata[SHIFT_W-1:0]);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_and_first_edges;
      access_window_shift(1'b0, '0);
      send_edge(32'h0000_0000);
      send_edge(32'hFFFF_FFFF);
      send_edge(32'hFFFF_FFFF);
      send_edge(32'h0000_0000);
   endtask

   // gaps right at and just past one and a half times the gap before
   task automatic test_turn_threshold;
      send_edge(stim_time + 32'd10);
      send_edge(stim_time + 32'd15);
      send_edge(stim_time + 32'd22);
      send_edge(stim_time + 32'd34);
      send_edge(stim_time + 32'd1);
   endtask

   task automatic test_gap_overflow;
      send_edge(stim_time + 32'hFFFF_FFFF);
      send_edge(stim_time + 32'hFFFF_FFFF);
      send_edge(stim_time + 32'h8000_0000);
   endtask

   task automatic test_mean_saturation;
      access_window_shift(1'b1, 32'd15);
      access_window_shift(1'b0, '0);
      repeat (4) begin
         send_edge(stim_time + 32'd1);
         send_edge(stim_time + 32'hF000_0000);
      end
      access_window_shift(1'b1, 32'h5A5A_5A51);
      access_window_shift(1'b0, '0);
      send_edge(stim_time + 32'd1);
      access_window_shift(1'b1, 32'd0);
      access_window_shift(1'b0, '0);
      send_edge(stim_time + 32'd1);
      send_edge(stim_time + 32'h100);
   endtask

   // mostly revolutions: a burst of close edges, then the long gap to the next turn
   task automatic test_random_stream(input int tx_pct, input int rx_pct, input int count,
                                     input logic [SHIFT_W-1:0] shift);
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] base;
      logic [TIME_W-1:0] step;
      logic [TIME_W-1:0] spent;
      int                burst;
      int                sent;
      bit                paused;
      access_window_shift(1'b1, {{(CSR_DATA_W-SHIFT_W){1'b0}}, shift});
      access_window_shift(1'b0, '0);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      sent   = 0;
      paused = 1'b0;
      while (sent < count) begin
         if (!paused && sent >= count / 2) begin
            paused = 1'b1;
            drain_results();
         end
         if ($urandom_range(9) < 2) begin
            if ($urandom_range(1))
               send_edge($urandom);
            else
               send_edge(stim_time + $urandom_range(50, 0));
            sent++;
         end else begin
            case ($urandom_range(7))
               0: span = $urandom_range(64, 2);
               1: span = $urandom | 32'h8000_0000;
               default: span = $urandom_range(200_000, 200);
            endcase
            burst = $urandom_range(5, 0);
            base  = span / (4 * (burst + 1));
            if (base == 0)
               base = 1;
            base  = $urandom_range(base, 1);
            spent = '0;
            for (int i = 0; i < burst; i++) begin
               step  = base + $urandom_range(base / 2, 0);
               spent = spent + step;
               send_edge(stim_time + step);
            end
            send_edge(stim_time + span - spent);
            sent += burst + 1;
         end
      end
   endtask

   // output held off while edges keep coming, so the block stalls its input
   task automatic test_output_backpressure;
      drain_results();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      long_hold_cycles = 300;
      repeat (60)
         send_edge(stim_time + $urandom_range(1000, 1));
      drain_results();
   endtask

   always @(posedge clock) begin
      if (hold_done < long_hold_cycles) begin
         hold_done <= hold_done + 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected rsp beat, expected none, actual period %h",
                     $time, rsp_turn_period);
            mismatch_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            check_field("new_turn", TIME_W'(oldest_result.new_turn), TIME_W'(rsp_new_turn));
            check_field("turn_period", oldest_result.turn_period, rsp_turn_period);
            check_field("turn_start", oldest_result.turn_start, rsp_turn_start);
            check_field("slot_index", TIME_W'(oldest_result.slot_index),
                        TIME_W'(rsp_slot_index));
            check_field("mean_period", oldest_result.mean_period, rsp_mean_period);
            check_field("turn_count", TIME_W'(oldest_result.turn_count),
                        TIME_W'(rsp_turn_count));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("revolution_period_tracker test failed");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      rx_idle_pct = 30;
      test_reset_and_first_edges();
      test_turn_threshold();
      test_gap_overflow();
      test_mean_saturation();
      test_random_stream(13, 77, 540, SHIFT_W'($urandom_range(15, 1)));
      test_random_stream(77, 13, 540, 4'd1);
      test_random_stream(0, 0, 540, 4'd15);
      test_output_backpressure();
      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("revolution_period_tracker test passed");
      end else begin
         $display("revolution_period_tracker test failed");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/rpt_pkg.sv
hw/rtl/rpt_update.sv
hw/rtl/revolution_period_tracker.sv
tb/sv/testbench.sv
